// ===== sv/gri_pkg.sv =====
// Shared widths, types and limits of the gyro rate frame integrator.
package gri_pkg;

  // Longest elapsed time, in microseconds, charged to one interval
  localparam int unsigned DT_CAP = 1048575;

  localparam int unsigned DT_W    = $clog2(DT_CAP + 1);
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned DELTA_W = 48;
  localparam int unsigned TOTAL_W = 56;
  // Signed rate times nonnegative dt below 2^DT_W
  localparam int unsigned PIECE_W = RATE_W + DT_W;

  localparam int unsigned IN_DATA_W  = TIME_W + 3 * RATE_W;
  localparam int unsigned OUT_DATA_W = 3 * DELTA_W + 3 * TOTAL_W;

  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic signed [PIECE_W-1:0] piece_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  typedef struct packed {
    logic valid;
    logic frame;
  } stage_ctl_t;

endpackage

// ===== sv/gyro_rate_frame_integrator.sv =====
// Top level of the gyro rate frame integrator: stages, result register, handshake.
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   event_time, rate_x, rate_y, rate_z (120b)   cmd (1 = frame)
//  m_axis   out  delta_x/y/z, total_x/y/z (312b)             -
//
// One word enters every cycle unless the stages are stalled; a frame word passes the
// dt register, the multiply register and the accumulate into the result register,
// where its result becomes valid. Gyro words update state and give no result.
// All stages advance together; a result held in the output register stalls them
// and deasserts s_axis_tready until m_axis_tready takes it.
// Reset clears held rates, last time, accumulators and the stage valid bits.
module gyro_rate_frame_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gri_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // event_time, rate_x, rate_y, rate_z
  input  logic                              s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gri_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // delta_x/y/z, total_x/y/z
);

  localparam int unsigned RX_LO = gri_pkg::TIME_W;
  localparam int unsigned RY_LO = RX_LO + gri_pkg::RATE_W;
  localparam int unsigned RZ_LO = RY_LO + gri_pkg::RATE_W;

  logic                             en;
  logic                             out_valid_q;
  logic [gri_pkg::OUT_DATA_W-1:0]   out_data_q;
  gri_pkg::stage_ctl_t              s2_ctl;
  gri_pkg::piece_t                  px, py, pz;
  gri_pkg::delta_t                  dx, dy, dz;
  gri_pkg::total_t                  tx, ty, tz;

  // Advance whenever the result register is empty or being drained
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  gri_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .cmd_i       (s_axis_tuser),
    .event_time_i(s_axis_tdata[gri_pkg::TIME_W-1:0]),
    .rate_x_i    (s_axis_tdata[RX_LO +: gri_pkg::RATE_W]),
    .rate_y_i    (s_axis_tdata[RY_LO +: gri_pkg::RATE_W]),
    .rate_z_i    (s_axis_tdata[RZ_LO +: gri_pkg::RATE_W]),
    .ctl_o       (s2_ctl),
    .piece_x_o   (px),
    .piece_y_o   (py),
    .piece_z_o   (pz)
  );

  gri_axis_acc u_acc_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s2_ctl),
    .piece_i(px),
    .delta_o(dx),
    .total_o(tx)
  );

  gri_axis_acc u_acc_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s2_ctl),
    .piece_i(py),
    .delta_o(dy),
    .total_o(ty)
  );

  gri_axis_acc u_acc_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s2_ctl),
    .piece_i(pz),
    .delta_o(dz),
    .total_o(tz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_ctl.valid && s2_ctl.frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_ctl.valid && s2_ctl.frame) begin
      out_data_q <= {tz, ty, tx, dz, dy, dx};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_frame_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_ctl.valid && s2_ctl.frame) |=> m_axis_tvalid)
    else $error("frame word in accumulate stage gave no result");

  a_gyro_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !(s2_ctl.valid && s2_ctl.frame)) |=> !m_axis_tvalid)
    else $error("result word without a frame word behind it");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(s2_ctl) && $stable(px)))
    else $error("stages moved while the result word was stalled");
`endif

endmodule

// ===== sv/gri_front.sv =====
// Elapsed-time stage, held rates and the rate-by-time multiply stage.
module gri_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic                          cmd_i,
  input  logic [gri_pkg::TIME_W-1:0]    event_time_i,
  input  gri_pkg::rate_t                rate_x_i,
  input  gri_pkg::rate_t                rate_y_i,
  input  gri_pkg::rate_t                rate_z_i,
  output gri_pkg::stage_ctl_t           ctl_o,
  output gri_pkg::piece_t               piece_x_o,
  output gri_pkg::piece_t               piece_y_o,
  output gri_pkg::piece_t               piece_z_o
);

  function automatic gri_pkg::piece_t mul_piece(gri_pkg::rate_t r,
                                                logic [gri_pkg::DT_W-1:0] d);
    logic signed [gri_pkg::PIECE_W:0] p;
    p = r * $signed({1'b0, d});
    return p[gri_pkg::PIECE_W-1:0];
  endfunction

  logic                       accept;
  logic [gri_pkg::TIME_W-1:0] prev_time_q;
  gri_pkg::rate_t             held_x_q, held_y_q, held_z_q;
  logic [gri_pkg::TIME_W-1:0] span;
  logic [gri_pkg::DT_W-1:0]   dt_d;

  gri_pkg::stage_ctl_t        s1_ctl_q, s2_ctl_q;
  logic [gri_pkg::DT_W-1:0]   s1_dt_q;
  gri_pkg::rate_t             s1_rx_q, s1_ry_q, s1_rz_q;
  gri_pkg::piece_t            s2_px_q, s2_py_q, s2_pz_q;

  assign accept = en_i && in_valid_i;

  // A backward step counts as no elapsed time; long gaps are capped
  always_comb begin
    span = (event_time_i > prev_time_q) ? (event_time_i - prev_time_q) : '0;
    if (span > gri_pkg::TIME_W'(gri_pkg::DT_CAP)) begin
      dt_d = gri_pkg::DT_W'(gri_pkg::DT_CAP);
    end else begin
      dt_d = span[gri_pkg::DT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= '0;
      s1_ctl_q    <= '0;
      s2_ctl_q    <= '0;
    end else if (en_i) begin
      s1_ctl_q <= '{valid: in_valid_i, frame: cmd_i};
      s2_ctl_q <= s1_ctl_q;
      if (accept) begin
        prev_time_q <= event_time_i;
        if (!cmd_i) begin
          held_x_q <= rate_x_i;
          held_y_q <= rate_y_i;
          held_z_q <= rate_z_i;
        end
      end
    end
  end

  // The interval ending at this word uses the rates held before it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dt_q <= dt_d;
      s1_rx_q <= held_x_q;
      s1_ry_q <= held_y_q;
      s1_rz_q <= held_z_q;
    end
    if (en_i && s1_ctl_q.valid) begin
      s2_px_q <= mul_piece(s1_rx_q, s1_dt_q);
      s2_py_q <= mul_piece(s1_ry_q, s1_dt_q);
      s2_pz_q <= mul_piece(s1_rz_q, s1_dt_q);
    end
  end

  assign ctl_o     = s2_ctl_q;
  assign piece_x_o = s2_px_q;
  assign piece_y_o = s2_py_q;
  assign piece_z_o = s2_pz_q;

endmodule

// ===== sv/gri_axis_acc.sv =====
// Saturating per-frame delta and running total accumulators of one axis.
module gri_axis_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  gri_pkg::stage_ctl_t ctl_i,
  input  gri_pkg::piece_t     piece_i,
  output gri_pkg::delta_t     delta_o,
  output gri_pkg::total_t     total_o
);

  localparam int unsigned DX = gri_pkg::DELTA_W + 1 - gri_pkg::PIECE_W;
  localparam int unsigned TX = gri_pkg::TOTAL_W + 1 - gri_pkg::PIECE_W;

  gri_pkg::delta_t            acc_delta_q;
  gri_pkg::total_t            acc_total_q;
  logic [gri_pkg::DELTA_W:0]  dsum;
  logic [gri_pkg::TOTAL_W:0]  tsum;
  gri_pkg::delta_t            dsat;
  gri_pkg::total_t            tsat;

  always_comb begin
    dsum = {acc_delta_q[gri_pkg::DELTA_W-1], acc_delta_q}
         + {{DX{piece_i[gri_pkg::PIECE_W-1]}}, piece_i};
    tsum = {acc_total_q[gri_pkg::TOTAL_W-1], acc_total_q}
         + {{TX{piece_i[gri_pkg::PIECE_W-1]}}, piece_i};
    // Clamp when the guard bit disagrees with the sign bit
    if (dsum[gri_pkg::DELTA_W] != dsum[gri_pkg::DELTA_W-1]) begin
      dsat = dsum[gri_pkg::DELTA_W] ? {1'b1, {(gri_pkg::DELTA_W-1){1'b0}}}
                                    : {1'b0, {(gri_pkg::DELTA_W-1){1'b1}}};
    end else begin
      dsat = dsum[gri_pkg::DELTA_W-1:0];
    end
    if (tsum[gri_pkg::TOTAL_W] != tsum[gri_pkg::TOTAL_W-1]) begin
      tsat = tsum[gri_pkg::TOTAL_W] ? {1'b1, {(gri_pkg::TOTAL_W-1){1'b0}}}
                                    : {1'b0, {(gri_pkg::TOTAL_W-1){1'b1}}};
    end else begin
      tsat = tsum[gri_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_delta_q <= '0;
      acc_total_q <= '0;
    end else if (en_i && ctl_i.valid) begin
      acc_total_q <= tsat;
      // Drop the delta once a frame word has taken it
      acc_delta_q <= ctl_i.frame ? '0 : dsat;
    end
  end

  assign delta_o = dsat;
  assign total_o = tsat;

endmodule

// ===== tb/gyro_angle_checker.sv =====
// Watches both streams of the integrator, predicts frame angles and compares them.
`timescale 1ns / 100ps
module gyro_angle_checker
  import gri_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // event_time, rate_x, rate_y, rate_z
  input  logic                  s_axis_tuser,  // cmd
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // delta_x/y/z, total_x/y/z
  output int                    err_count_o,
  output int                    pending_o
);

  localparam longint DELTA_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DELTA_MIN = -DELTA_MAX - 1;
  localparam longint TOTAL_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 1;

  typedef struct {
    delta_t delta[3];
    total_t total[3];
  } frame_angles_t;

  rate_t               held_rate[3];
  logic [TIME_W-1:0]   prev_time_us;
  delta_t              acc_delta[3];
  total_t              acc_total[3];
  frame_angles_t       frame_angles_q[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count_o++;
  endtask

  // Charge the elapsed interval to the held rates, then load rates or close the frame
  task automatic integrate_event(input logic is_frame, input logic [IN_DATA_W-1:0] word);
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] span;
    longint            piece;
    frame_angles_t     fa;
    t    = word[TIME_W-1:0];
    span = '0;
    if (t > prev_time_us) span = t - prev_time_us;
    if (span > TIME_W'(DT_CAP)) span = TIME_W'(DT_CAP);
    prev_time_us = t;
    for (int i = 0; i < 3; i++) begin
      piece = longint'(held_rate[i]) * longint'(span);
      acc_delta[i] = delta_t'(clamp(longint'(acc_delta[i]) + piece, DELTA_MIN, DELTA_MAX));
      acc_total[i] = total_t'(clamp(longint'(acc_total[i]) + piece, TOTAL_MIN, TOTAL_MAX));
    end
    if (!is_frame) begin
      for (int i = 0; i < 3; i++) held_rate[i] = word[TIME_W + i*RATE_W +: RATE_W];
    end else begin
      for (int i = 0; i < 3; i++) begin
        fa.delta[i]  = acc_delta[i];
        fa.total[i]  = acc_total[i];
        acc_delta[i] = '0;
      end
      frame_angles_q = {frame_angles_q, fa};
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    frame_angles_t want;
    delta_t        got_d;
    total_t        got_t;
    string         axis;
    axis = "xyz";
    if (frame_angles_q.size() == 0) begin
      report_mismatch("result word with no frame pending");
    end else begin
      want = frame_angles_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        got_d = word[i*DELTA_W +: DELTA_W];
        got_t = word[3*DELTA_W + i*TOTAL_W +: TOTAL_W];
        if (got_d !== want.delta[i])
          report_mismatch($sformatf("delta_%c got %0d expected %0d",
                                    axis[i], got_d, want.delta[i]));
        if (got_t !== want.total[i])
          report_mismatch($sformatf("total_%c got %0d expected %0d",
                                    axis[i], got_t, want.total[i]));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        held_rate[i] = '0;
        acc_delta[i] = '0;
        acc_total[i] = '0;
      end
      prev_time_us = '0;
      frame_angles_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) integrate_event(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      pending_o = frame_angles_q.size();
    end
  end

endmodule

// ===== tb/gyro_rate_frame_integrator_tb.sv =====
// Testbench top of the gyro rate frame integrator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module gyro_rate_frame_integrator_tb;
  import gri_pkg::*;

  localparam rate_t RATE_MAX = 24'sh7FFFFF;
  localparam rate_t RATE_MIN = 24'sh800000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int                    err_count;
  int                    pending;
  logic                  idle_en = 1'b1;
  logic [TIME_W-1:0]     now_us  = '0;

  gyro_rate_frame_integrator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gyro_angle_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stall the result side at random unless idling is switched off
  always @(negedge clk_i) begin
    m_axis_tready <= !idle_en || ($urandom_range(99, 0) >= 19);
  end

  function automatic rate_t pick_rate();
    case ($urandom_range(19, 0))
      0:       return RATE_MAX;
      1:       return RATE_MIN;
      2:       return '0;
      3:       return '1;
      default: return rate_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic is_frame, input logic [TIME_W-1:0] t,
                           input rate_t rx, input rate_t ry, input rate_t rz);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99, 0) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_frame;
    s_axis_tdata  <= {rz, ry, rx, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the input side until every pending frame word has come out
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random_event(input int frame_pct);
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 5)       now_us = now_us;
    else if (sel < 45) now_us = now_us + $urandom_range(1000, 1);
    else if (sel < 75) now_us = now_us + $urandom_range(DT_CAP, 1);
    else if (sel < 90) now_us = now_us + DT_CAP + $urandom_range(1 << 24, 1);
    else if (sel < 95) now_us = now_us - $urandom_range(5000, 1);
    else               now_us = TIME_W'({$urandom, $urandom});
    send_word($urandom_range(99, 0) < frame_pct, now_us, pick_rate(), pick_rate(), pick_rate());
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] t_mark;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero state, field extremes, capped and backward steps, time wrap
    send_word(1'b1, 48'd0, '0, '0, '0);
    send_word(1'b0, 48'd10, RATE_MAX, RATE_MIN, '0);
    send_word(1'b1, 48'd1010, pick_rate(), pick_rate(), pick_rate());
    t_mark = 48'd1010 + DT_CAP + 5000;
    send_word(1'b0, t_mark, RATE_MIN, RATE_MAX, '1);
    t_mark = t_mark + DT_CAP;
    send_word(1'b1, t_mark, pick_rate(), pick_rate(), pick_rate());
    t_mark = t_mark - 500;
    send_word(1'b0, t_mark, 24'sd1, -24'sd1, 24'sh5A5A5A);
    send_word(1'b1, t_mark, RATE_MAX, RATE_MIN, RATE_MAX);
    send_word(1'b0, 48'hFFFF_FFFF_FFFF, RATE_MAX, RATE_MAX, RATE_MIN);
    send_word(1'b1, 48'hFFFF_FFFF_FFFF, pick_rate(), pick_rate(), pick_rate());
    send_word(1'b0, 48'd0, RATE_MAX, RATE_MAX, RATE_MAX);
    send_word(1'b0, 48'd1 + DT_CAP, RATE_MIN, RATE_MIN, RATE_MIN);
    send_word(1'b1, 48'd2 + DT_CAP, pick_rate(), pick_rate(), pick_rate());
    send_word(1'b1, 48'd3 + DT_CAP, pick_rate(), pick_rate(), pick_rate());
    now_us = 48'd3 + DT_CAP;
    drain_results();

    for (int n = 0; n < 1500; n++) begin
      idle_en = !(n >= 600 && n < 1000);
      send_random_event(20);
    end
    idle_en = 1'b1;
    drain_results();

    // Drive x up and y down at full rate and full interval so that the deltas can clip
    now_us = TIME_W'($urandom);
    for (int n = 0; n < 400; n++) begin
      now_us = now_us + DT_CAP + $urandom_range(64, 0);
      send_word($urandom_range(19, 0) == 0, now_us, RATE_MAX, RATE_MIN,
                $urandom_range(1, 0) ? RATE_MAX : RATE_MIN);
    end
    for (int n = 0; n < 100; n++) send_random_event(30);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gri_pkg.sv
sv/gri_front.sv
sv/gri_axis_acc.sv
sv/gyro_rate_frame_integrator.sv
tb/gyro_angle_checker.sv
tb/gyro_rate_frame_integrator_tb.sv
